// ===== hw/rtl/assert_macros.svh =====
// assertion helpers included by tse_dpath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TSE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tse assertion failed");

// same-cycle implication
`define TSE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tse assertion failed");

`endif

// ===== hw/rtl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the topological sort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;

  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT_RD,
    S_COUNT_ACC,
    S_SEED,
    S_POP,
    S_POP_WAIT,
    S_HANDOFF,
    S_SCAN,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic row_wr;
    logic start;
    logic adj_sel_v;
    logic count_acc;
    logic seed_step;
    logic pop;
    logic take_v;
    logic handoff;
    logic scan_step;
    logic final_load;
  } tse_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic cnt_last;
    logic stack_empty;
    logic slot_free;
    logic pending_valid;
  } tse_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/topological_sort_engine.sv =====
// ----------------------------------------------------------------------------
// topological_sort_engine
// Kahn topological sort over an adjacency matrix loaded one row per item.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the engine is idle; a row with last_row
// set starts the sort and the engine takes no further item until the final
// result has been placed in the output register. For n vertices the sort
// counts in-degrees (a read and an accumulate step per vertex), seeds the
// ready stack, then pops each vertex, hands it off and scans its successors,
// and finishes with the final item; the output side can stall the run. The
// single read port of the adjacency RAM and the one-successor-per-cycle scan
// set the run time. The user must see that the vertex count register is written
// only while idle (the block does not enforce it); the value used is saturated to 16.
`timescale 1ns / 1ps
`default_nettype none

module topological_sort_engine import tse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  row_index,
  input  logic [15:0] row_bits,
  input  logic        last_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  vertex,
  output logic        vertex_valid,
  output logic        has_cycle,
  output logic        last
);

  tse_cmd_t  cmd;
  tse_stat_t stat;

  tse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_row (last_row),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tse_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex       (vertex),
    .vertex_valid (vertex_valid),
    .has_cycle    (has_cycle),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tse_ram.sv =====
// ----------------------------------------------------------------------------
// tse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tse_ctrl.sv =====
// ----------------------------------------------------------------------------
// tse_ctrl
// Sequencer for row loading, in-degree count, seeding, pop/scan and final item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tse_ctrl import tse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last_row,
  output logic      in_ready,
  input  tse_stat_t stat,
  output tse_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   handoff_go;

  assign handoff_go = stat.slot_free || !stat.pending_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && last_row) begin
          state_next = stat.n_zero ? S_FINAL : S_COUNT_RD;
        end
      end
      S_COUNT_RD:  state_next = S_COUNT_ACC;
      S_COUNT_ACC: state_next = stat.cnt_last ? S_SEED : S_COUNT_RD;
      S_SEED:      state_next = stat.cnt_last ? S_POP : S_SEED;
      S_POP:       state_next = stat.stack_empty ? S_FINAL : S_POP_WAIT;
      S_POP_WAIT:  state_next = S_HANDOFF;
      S_HANDOFF:   state_next = handoff_go ? S_SCAN : S_HANDOFF;
      S_SCAN:      state_next = stat.cnt_last ? S_POP : S_SCAN;
      S_FINAL:     state_next = stat.slot_free ? S_IDLE : S_FINAL;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd            = '0;
    cmd.row_wr     = in_ready && in_valid;
    cmd.start      = in_ready && in_valid && last_row;
    cmd.adj_sel_v  = (state == S_HANDOFF) || (state == S_SCAN);
    cmd.count_acc  = (state == S_COUNT_ACC);
    cmd.seed_step  = (state == S_SEED);
    cmd.pop        = (state == S_POP) && !stat.stack_empty;
    cmd.take_v     = (state == S_POP_WAIT);
    cmd.handoff    = (state == S_HANDOFF) && handoff_go;
    cmd.scan_step  = (state == S_SCAN);
    cmd.final_load = (state == S_FINAL) && stat.slot_free;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tse_dpath.sv =====
// ----------------------------------------------------------------------------
// tse_dpath
// Adjacency and stack memories, in-degree counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tse_dpath import tse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tse_cmd_t  cmd,
  output tse_stat_t stat,
  input  logic      cfg_we,
  input  cnt_t      cfg_data,
  input  vidx_t     row_index,
  input  row_t      row_bits,
  output logic      out_valid,
  input  logic      out_ready,
  output vidx_t     vertex,
  output logic      vertex_valid,
  output logic      has_cycle,
  output logic      last
);

  cnt_t  vertex_count;
  cnt_t  n_sat;
  cnt_t  n_reg;
  vidx_t cnt;
  cnt_t  in_degree [MAX_VERTICES];
  cnt_t  depth;
  cnt_t  emitted;
  vidx_t cur_v;
  vidx_t pending;
  logic  pending_valid;

  row_t  adj_rd;
  vidx_t stack_rd;
  vidx_t adj_raddr;
  logic  cnt_last;
  logic  seed_push;
  logic  scan_hit;
  logic  scan_push;
  logic  push;
  logic  slot_free;

  assign n_sat = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;

  assign cnt_last  = ({1'b0, cnt} == (n_reg - CNT_W'(1)));
  assign seed_push = cmd.seed_step && (in_degree[cnt] == '0);
  assign scan_hit  = cmd.scan_step && adj_rd[cnt] && (in_degree[cnt] != '0);
  assign scan_push = scan_hit && (in_degree[cnt] == CNT_W'(1));
  assign push      = seed_push || scan_push;
  assign slot_free = !out_valid || out_ready;
  assign adj_raddr = cmd.adj_sel_v ? cur_v : cnt;

  assign stat.n_zero        = (n_sat == '0);
  assign stat.cnt_last      = cnt_last;
  assign stat.stack_empty   = (depth == '0);
  assign stat.slot_free     = slot_free;
  assign stat.pending_valid = pending_valid;

  tse_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (cmd.row_wr),
    .waddr (row_index),
    .wdata (row_bits),
    .raddr (adj_raddr),
    .rdata (adj_rd)
  );

  // lifo of vertices whose in-degree is zero
  tse_ram #(
    .WIDTH (VIDX_W),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push),
    .waddr (depth[VIDX_W-1:0]),
    .wdata (cnt),
    .raddr (VIDX_W'(depth - CNT_W'(1))),
    .rdata (stack_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(MAX_VERTICES);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg         <= '0;
      cnt           <= '0;
      depth         <= '0;
      emitted       <= '0;
      pending_valid <= 1'b0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
        in_degree[j] <= '0;
      end
    end else begin
      if (cmd.start) begin
        n_reg         <= n_sat;
        cnt           <= '0;
        depth         <= '0;
        emitted       <= '0;
        pending_valid <= 1'b0;
        for (int j = 0; j < MAX_VERTICES; j++) begin
          in_degree[j] <= '0;
        end
      end else begin
        // counter wraps to zero at the end of each sweep
        if (cmd.count_acc || cmd.seed_step || cmd.scan_step) begin
          cnt <= cnt_last ? '0 : cnt + VIDX_W'(1);
        end
        if (cmd.count_acc) begin
          for (int j = 0; j < MAX_VERTICES; j++) begin
            if (adj_rd[j] && (CNT_W'(j) < n_reg)) begin
              in_degree[j] <= in_degree[j] + CNT_W'(1);
            end
          end
        end
        if (scan_hit) begin
          in_degree[cnt] <= in_degree[cnt] - CNT_W'(1);
        end
        if (cmd.pop) begin
          depth <= depth - CNT_W'(1);
        end else if (push) begin
          depth <= depth + CNT_W'(1);
        end
        if (cmd.handoff) begin
          emitted       <= emitted + CNT_W'(1);
          pending_valid <= 1'b1;
        end else if (cmd.final_load) begin
          pending_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_v) begin
      cur_v <= stack_rd;
    end
    if (cmd.handoff) begin
      pending <= cur_v;
    end
  end

  // output register: a popped vertex is held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.handoff && pending_valid) || cmd.final_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.handoff && pending_valid) begin
      vertex       <= pending;
      vertex_valid <= 1'b1;
      has_cycle    <= 1'b0;
      last         <= 1'b0;
    end else if (cmd.final_load) begin
      vertex       <= pending_valid ? pending : '0;
      vertex_valid <= pending_valid;
      has_cycle    <= pending_valid ? (emitted < n_reg) : (n_reg != '0);
      last         <= 1'b1;
    end
  end

  `TSE_ASSERT_ALWAYS(a_depth_bound, clk, rst, depth <= CNT_W'(MAX_VERTICES))
  `TSE_ASSERT_IMPL(a_push_room, clk, rst, push, depth < CNT_W'(MAX_VERTICES))
  `TSE_ASSERT_IMPL(a_pop_nonempty, clk, rst, cmd.pop, depth != '0)
  `TSE_ASSERT_ALWAYS(a_emitted_bound, clk, rst, emitted <= n_reg)

endmodule

`default_nettype wire
